// File: src/sabc_pkg.sv
// Shared types and constants for the set-associative block cache.
// No dependencies.
package sabc_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned FIELD_DATA_W  = 48;
  localparam int unsigned ACTION_W      = 3;
  localparam int unsigned WAY_OUT_W     = 5;
  localparam int unsigned SHIFT_W       = 5;

  localparam int unsigned DEF_NUM_SETS  = 256;
  localparam int unsigned DEF_NUM_WAYS  = 4;
  localparam int unsigned DEF_DATA_BITS = 48;

  localparam logic [SHIFT_W-1:0] SET_SHIFT_RESET = 5'd1;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INV_ADDR = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_INV_DATA = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_INV_ALL  = 3'd4;

  typedef enum logic [2:0] {
    OP_LOOKUP, OP_INSERT, OP_INV_ADDR, OP_INV_DATA, OP_INV_ALL, OP_NOP
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [ADDR_W-1:0]       address;
    logic [FIELD_DATA_W-1:0] entry_data;
  } req_t;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN} st_t;

endpackage

// File: src/sabc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sabc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: src/sabc_front.sv
// Front end: config register, action decode and a two-entry request queue.
// Depends on sabc_pkg.
module sabc_front import sabc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ACTION_W-1:0]     in_action,
  input  logic [ADDR_W-1:0]       in_address,
  input  logic [FIELD_DATA_W-1:0] in_entry_data,
  input  logic                    cfg_we,
  input  logic [SHIFT_W-1:0]      cfg_wdata,
  output logic [SHIFT_W-1:0]      set_shift,
  output logic                    q_valid,
  output req_t                    q_item,
  input  logic                    q_pop
);

  req_t             item_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [SHIFT_W-1:0] shift_r;
  req_t             dec;
  logic             push;

  always_comb begin
    dec.address    = in_address;
    dec.entry_data = in_entry_data;
    unique case (in_action)
      ACT_LOOKUP:   dec.op = OP_LOOKUP;
      ACT_INSERT:   dec.op = OP_INSERT;
      ACT_INV_ADDR: dec.op = OP_INV_ADDR;
      ACT_INV_DATA: dec.op = OP_INV_DATA;
      ACT_INV_ALL:  dec.op = OP_INV_ALL;
      default:      dec.op = OP_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = item_r[rd_ptr_r];
  assign set_shift = shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      shift_r  <= SET_SHIFT_RESET;
    end else begin
      if (cfg_we) begin
        shift_r <= cfg_wdata;
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: src/sabc_back.sv
// Back end: tag/data/PLRU memories, execution sequencer and result register.
// Depends on sabc_pkg and sabc_ram.
module sabc_back import sabc_pkg::*; #(
  parameter int unsigned NUM_SETS  = DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS  = DEF_NUM_WAYS,
  parameter int unsigned DATA_BITS = DEF_DATA_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SHIFT_W-1:0]      set_shift,
  input  logic                    q_valid,
  input  req_t                    q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [FIELD_DATA_W-1:0] out_hit_data,
  output logic [WAY_OUT_W-1:0]    out_way_used
);

  localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned RAM_SETS = (NUM_SETS > 1) ? NUM_SETS : 2;
  localparam int unsigned WAY_W = $clog2(NUM_WAYS);
  localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);

  st_t                  state_r, state_nxt;
  req_t                 cur_r, cur_nxt;
  logic [SET_W-1:0]     cur_set_r, cur_set_nxt, scan_set_r, scan_set_nxt;
  logic [NUM_SETS-1:0]  row_ok_r, row_ok_nxt;

  logic                    out_valid_r, out_valid_nxt, out_hit_r, out_hit_nxt;
  logic [FIELD_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [WAY_OUT_W-1:0]    out_way_r, out_way_nxt;
  logic                    out_free, out_load;

  logic                    rd_en;
  logic [SET_W-1:0]        rd_addr, head_set, act_set;
  logic [NUM_WAYS-1:0]     entry_we;
  logic                    meta_we;
  logic [2*NUM_WAYS-1:0]   meta_wdata, meta_rd;
  logic [ADDR_W-1:0]       tag_rd  [NUM_WAYS];
  logic [DATA_BITS-1:0]    data_rd [NUM_WAYS];

  logic [NUM_WAYS-1:0] row_valid, row_plru, tag_match, data_match;
  logic                tag_hit, data_hit, victim_found;
  logic [WAY_W-1:0]    tag_way, data_way, victim_way;
  logic [DATA_BITS-1:0] cmp_data;

  function automatic logic [NUM_WAYS-1:0] touch_bits(input logic [NUM_WAYS-1:0] plru,
                                                     input logic [WAY_W-1:0] way);
    logic [NUM_WAYS-1:0] bit_m, cur;
    bit_m = '0;
    bit_m[way] = 1'b1;
    cur = plru & ~bit_m;
    if (cur == '0) begin
      cur = ~bit_m;
    end
    return cur;
  endfunction

  assign head_set = SET_W'(q_item.address >> set_shift) & SET_MASK;
  assign act_set  = (state_r == ST_SCAN) ? scan_set_r : cur_set_r;
  assign cmp_data = DATA_BITS'(cur_r.entry_data);

  for (genvar w = 0; w < NUM_WAYS; w++) begin : g_way
    sabc_ram #(.WIDTH(ADDR_W), .DEPTH(RAM_SETS)) u_tag (
      .clk, .we(entry_we[w]), .waddr(act_set), .wdata(cur_r.address),
      .re(rd_en), .raddr(rd_addr), .rdata(tag_rd[w])
    );
    sabc_ram #(.WIDTH(DATA_BITS), .DEPTH(RAM_SETS)) u_data (
      .clk, .we(entry_we[w]), .waddr(act_set), .wdata(cmp_data),
      .re(rd_en), .raddr(rd_addr), .rdata(data_rd[w])
    );
  end

  // low half: valid bits, high half: not-recently-used bits
  sabc_ram #(.WIDTH(2*NUM_WAYS), .DEPTH(RAM_SETS)) u_meta (
    .clk, .we(meta_we), .waddr(act_set), .wdata(meta_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(meta_rd)
  );

  // a row never written since the last flush reads as all invalid, all NRU set
  always_comb begin
    row_valid = row_ok_r[act_set] ? meta_rd[NUM_WAYS-1:0] : '0;
    row_plru  = row_ok_r[act_set] ? meta_rd[2*NUM_WAYS-1:NUM_WAYS] : '1;
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_match[w]  = row_valid[w] && (tag_rd[w] == cur_r.address);
      data_match[w] = row_valid[w] && (data_rd[w] == cmp_data);
    end
    tag_hit = 1'b0; tag_way = '0;
    data_hit = 1'b0; data_way = '0;
    victim_found = 1'b0; victim_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (tag_match[w]) begin
        tag_hit = 1'b1; tag_way = WAY_W'(w);
      end
      if (data_match[w]) begin
        data_hit = 1'b1; data_way = WAY_W'(w);
      end
      if (row_plru[w]) begin
        victim_found = 1'b1; victim_way = WAY_W'(w);
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    logic [NUM_WAYS-1:0] bit_m;
    bit_m         = '0;
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cur_set_nxt   = cur_set_r;
    scan_set_nxt  = scan_set_r;
    row_ok_nxt    = row_ok_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = head_set;
    entry_we      = '0;
    meta_we       = 1'b0;
    meta_wdata    = {row_plru, row_valid};
    out_load      = 1'b0;
    out_hit_nxt   = 1'b0;
    out_data_nxt  = '0;
    out_way_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cur_nxt     = q_item;
          cur_set_nxt = head_set;
          rd_en       = 1'b1;
          if (q_item.op == OP_INV_DATA) begin
            scan_set_nxt = '0;
            rd_addr      = '0;
            state_nxt    = ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          case (cur_r.op)
            OP_LOOKUP: begin
              if (tag_hit) begin
                out_hit_nxt  = 1'b1;
                out_data_nxt = FIELD_DATA_W'(data_rd[tag_way]);
                out_way_nxt  = WAY_OUT_W'(tag_way);
                meta_we      = 1'b1;
                meta_wdata   = {touch_bits(row_plru, tag_way), row_valid};
              end
            end
            OP_INSERT: begin
              bit_m[victim_found ? victim_way : '0] = 1'b1;
              entry_we    = bit_m;
              meta_we     = 1'b1;
              meta_wdata  = {touch_bits(row_plru, victim_found ? victim_way : '0),
                             row_valid | bit_m};
              out_way_nxt = WAY_OUT_W'(victim_found ? victim_way : '0);
            end
            OP_INV_ADDR: begin
              if (tag_hit) begin
                bit_m[tag_way] = 1'b1;
                meta_we     = 1'b1;
                meta_wdata  = {row_plru | bit_m, row_valid & ~bit_m};
                out_hit_nxt = 1'b1;
                out_way_nxt = WAY_OUT_W'(tag_way);
              end
            end
            OP_INV_ALL: begin
              row_ok_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (data_hit) begin
          if (out_free) begin
            bit_m[data_way] = 1'b1;
            meta_we     = 1'b1;
            meta_wdata  = {row_plru, row_valid & ~bit_m};
            out_load    = 1'b1;
            out_hit_nxt = 1'b1;
            out_way_nxt = WAY_OUT_W'(data_way);
            state_nxt   = ST_IDLE;
          end
        end else if (scan_set_r == SET_MASK) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          scan_set_nxt = scan_set_r + 1'b1;
          rd_en        = 1'b1;
          rd_addr      = scan_set_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (meta_we) begin
      row_ok_nxt[act_set] = 1'b1;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_ok_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_ok_r    <= row_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cur_set_r  <= cur_set_nxt;
    scan_set_r <= scan_set_nxt;
    if (out_load) begin
      out_hit_r  <= out_hit_nxt;
      out_data_r <= out_data_nxt;
      out_way_r  <= out_way_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_hit_data = out_data_r;
  assign out_way_used = out_way_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE)
    else $error("request popped while busy");
  a_meta_busy: assert property (@(posedge clk) disable iff (!rst_n)
    meta_we |-> out_load)
    else $error("row written without a result");
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_free && cur_r.op == OP_INV_ALL) |=> row_ok_r == '0)
    else $error("flush left rows live");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

endmodule

// File: src/set_assoc_block_cache_plru_top.sv
// Top level of the set-associative block cache with bit-PLRU replacement.
// Depends on sabc_pkg, sabc_front, sabc_back (and sabc_ram below it).
//
//  channel  ports                                      handshake
//  in       in_action, in_address, in_entry_data       in_valid / in_stall
//  out      out_hit, out_hit_data, out_way_used        out_valid / out_stall
//  cfg      cfg_wdata (set shift)                      cfg_we
//
// Lookup, insert, invalidate by address, invalidate all: one memory read then one
// read-modify-write of the set.
// Invalidate by data: one set read per cycle, until a data hit or the last set.
// Per-row live bits in flops stand for the cleared PLRU and valid memory after
// reset, so no clearing pass runs. A two-item queue and the result register
// let input and output stall independently.
module set_assoc_block_cache_plru_top import sabc_pkg::*; #(
  parameter int unsigned NUM_SETS  = DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS  = DEF_NUM_WAYS,
  parameter int unsigned DATA_BITS = DEF_DATA_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ACTION_W-1:0]     in_action,
  input  logic [ADDR_W-1:0]       in_address,
  input  logic [FIELD_DATA_W-1:0] in_entry_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [FIELD_DATA_W-1:0] out_hit_data,
  output logic [WAY_OUT_W-1:0]    out_way_used,
  input  logic                    cfg_we,
  input  logic [SHIFT_W-1:0]      cfg_wdata
);

  logic               q_valid, q_pop;
  req_t               q_item;
  logic [SHIFT_W-1:0] set_shift;

  sabc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_address, .in_entry_data,
    .cfg_we, .cfg_wdata, .set_shift, .q_valid, .q_item, .q_pop
  );

  sabc_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .DATA_BITS(DATA_BITS)
  ) u_back (
    .clk, .rst_n, .set_shift, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_hit, .out_hit_data, .out_way_used
  );

endmodule

// File: bench/tb_set_assoc_block_cache_plru_top.sv
// Self-checking bench for set_assoc_block_cache_plru_top: directed table, then
// random traffic over several set-shift settings. Depends on sabc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_set_assoc_block_cache_plru_top;
  import sabc_pkg::*;

  localparam int SETS = DEF_NUM_SETS;
  localparam int WAYS = DEF_NUM_WAYS;
  localparam int WATCHDOG_CYCLES = 6000;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                    hit;
    logic [FIELD_DATA_W-1:0] hit_data;
    logic [WAY_OUT_W-1:0]    way;
  } reply_t;

  typedef struct {
    logic [ACTION_W-1:0]     action;
    logic [ADDR_W-1:0]       address;
    logic [FIELD_DATA_W-1:0] entry_data;
    bit                      fixed;
    reply_t                  reply;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] in_action = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic [FIELD_DATA_W-1:0] in_entry_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [FIELD_DATA_W-1:0] out_hit_data;
  logic [WAY_OUT_W-1:0] out_way_used;
  logic cfg_we = 1'b0;
  logic [SHIFT_W-1:0] cfg_wdata = '0;

  set_assoc_block_cache_plru_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_address(in_address), .in_entry_data(in_entry_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_hit_data(out_hit_data), .out_way_used(out_way_used),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // cache shadow
  logic [ADDR_W-1:0]       tag_mem [SETS*WAYS];
  logic [FIELD_DATA_W-1:0] data_mem [SETS*WAYS];
  bit                      live [SETS*WAYS];
  logic [WAYS-1:0]         nru [SETS];
  logic [SHIFT_W-1:0]      shift_amt;

  reply_t pending_replies[$];
  logic [ADDR_W-1:0] known_tags[$];
  logic [FIELD_DATA_W-1:0] known_data[$];
  int mismatches = 0;
  int items_sent = 0;
  int replies_seen = 0;
  int hits_seen = 0;
  int idle_cycles = 0;
  int phases_run = 0;
  bit calm = 1'b0;

  function automatic int set_of(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] s;
    s = a >> shift_amt;
    return int'(s[7:0]);
  endfunction

  function automatic void touch_way(int s, int w);
    logic [WAYS-1:0] b;
    b = nru[s] & ~(WAYS'(1) << w);
    if (b == '0) b = ~(WAYS'(1) << w);
    nru[s] = b;
  endfunction

  function automatic int match_way(int s, logic [ADDR_W-1:0] a);
    for (int w = 0; w < WAYS; w++)
      if (live[s*WAYS+w] && tag_mem[s*WAYS+w] == a) return w;
    return -1;
  endfunction

  function automatic reply_t cache_apply(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] a,
                                         logic [FIELD_DATA_W-1:0] d);
    reply_t r;
    int s;
    int w;
    r = '0;
    s = set_of(a);
    case (act)
      ACT_LOOKUP: begin
        w = match_way(s, a);
        if (w >= 0) begin
          r.hit = 1'b1;
          r.hit_data = data_mem[s*WAYS+w];
          r.way = WAY_OUT_W'(w);
          touch_way(s, w);
        end
      end
      ACT_INSERT: begin
        w = 0;
        while (w < WAYS && !nru[s][w]) w++;
        if (w >= WAYS) w = 0;
        tag_mem[s*WAYS+w] = a;
        data_mem[s*WAYS+w] = d;
        live[s*WAYS+w] = 1'b1;
        touch_way(s, w);
        r.way = WAY_OUT_W'(w);
      end
      ACT_INV_ADDR: begin
        w = match_way(s, a);
        if (w >= 0) begin
          live[s*WAYS+w] = 1'b0;
          nru[s][w] = 1'b1;
          r.hit = 1'b1;
          r.way = WAY_OUT_W'(w);
        end
      end
      ACT_INV_DATA: begin
        for (int i = 0; i < SETS*WAYS; i++)
          if (live[i] && data_mem[i] == d) begin
            live[i] = 1'b0;
            r.hit = 1'b1;
            r.way = WAY_OUT_W'(i % WAYS);
            break;
          end
      end
      ACT_INV_ALL: begin
        for (int i = 0; i < SETS*WAYS; i++) live[i] = 1'b0;
        for (int i = 0; i < SETS; i++) nru[i] = '1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h (reply %0d)", what, got, want, replies_seen);
    mismatches++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // drive one item, then record what it must return once accepted
  task automatic send_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] a,
                           logic [FIELD_DATA_W-1:0] d, bit fixed, reply_t want);
    int gap;
    reply_t r;
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_address = a;
    in_entry_data = d;
    do @(posedge clk); while (in_stall);
    r = cache_apply(act, a, d);
    pending_replies.push_back(fixed ? want : r);
    items_sent++;
    if (act == ACT_INSERT) begin
      known_tags.push_back(a);
      known_data.push_back(d);
      if (known_tags.size() > 48) begin
        void'(known_tags.pop_front());
        void'(known_data.pop_front());
      end
    end
    @(negedge clk);
  endtask

  task automatic drain_and_pause();
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_shift(logic [SHIFT_W-1:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = SHIFT_W'($urandom);
    shift_amt = v;
  endtask

  function automatic logic [ADDR_W-1:0] fresh_addr();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] sel;
    // crowd a handful of sets so that ways fill and evict
    a = $urandom;
    sel = $urandom_range(0, 3);
    return (a & ~(32'hff << shift_amt)) | (sel << shift_amt);
  endfunction

  function automatic logic [FIELD_DATA_W-1:0] fresh_data();
    logic [31:0] hi;
    hi = $urandom;
    return {hi[15:0], 32'($urandom)};
  endfunction

  function automatic logic [ACTION_W-1:0] ACT_ACTION_SPARE();
    return ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
  endfunction

  task automatic random_item();
    int r;
    int k;
    logic [ACTION_W-1:0] act;
    logic [ADDR_W-1:0] a;
    logic [FIELD_DATA_W-1:0] d;
    r = $urandom_range(0, 99);
    a = fresh_addr();
    d = fresh_data();
    if (known_tags.size() > 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, known_tags.size() - 1);
      a = known_tags[k];
      if (r >= 80 || $urandom_range(0, 7) == 0) d = known_data[k];
    end
    if (r < 35) act = ACT_LOOKUP;
    else if (r < 65) act = ACT_INSERT;
    else if (r < 80) act = ACT_INV_ADDR;
    else if (r < 85) act = ACT_INV_DATA;
    else if (r < 87) act = ACT_INV_ALL;
    else if (r < 90) act = ACT_ACTION_SPARE();
    else act = ACT_LOOKUP;
    send_item(act, a, d, 1'b0, '0);
  endtask

  // result side: random stall, then check against the oldest expectation
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (calm) out_stall <= 1'b0;
    else if (out_stall) out_stall <= (r < 70);
    else out_stall <= (r < 25);
  end

  always @(posedge clk) begin
    reply_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("set_assoc_block_cache_plru_top regression: fail");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("unexpected result item (reply %0d)", replies_seen);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_hit) hits_seen++;
        if (out_hit !== want.hit) report_mismatch("hit", 64'(out_hit), 64'(want.hit));
        if (out_hit_data !== want.hit_data)
          report_mismatch("hit_data", 64'(out_hit_data), 64'(want.hit_data));
        if (out_way_used !== want.way)
          report_mismatch("way_used", 64'(out_way_used), 64'(want.way));
      end
    end
  end

  row_t plan[$];

  function automatic row_t mk(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] a,
                              logic [FIELD_DATA_W-1:0] d, bit fixed = 0,
                              reply_t want = '0);
    row_t t;
    t.action = act; t.address = a; t.entry_data = d; t.fixed = fixed; t.reply = want;
    return t;
  endfunction

  initial begin
    logic [SHIFT_W-1:0] shifts [6];
    for (int i = 0; i < SETS*WAYS; i++) live[i] = 1'b0;
    for (int i = 0; i < SETS; i++) nru[i] = '1;
    shift_amt = SET_SHIFT_RESET;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // after reset: misses and empty invalidates return all zero; first fill is way 0
    plan.push_back(mk(ACT_LOOKUP, 32'h0, 48'h0, 1));
    plan.push_back(mk(ACT_INV_ADDR, 32'hffff_ffff, 48'h0, 1));
    plan.push_back(mk(ACT_INV_DATA, 32'h0, 48'hffff_ffff_ffff, 1));
    plan.push_back(mk(ACT_INV_ALL, 32'h0, 48'h0, 1));
    plan.push_back(mk(ACT_SPARE_LO, 32'hffff_ffff, 48'hffff_ffff_ffff, 1));
    plan.push_back(mk(ACT_SPARE_HI, 32'h0, 48'h0, 1));
    plan.push_back(mk(ACT_INSERT, 32'h0, 48'h0, 1, '0));
    // same set (shift 1): 0, 0x200, 0x80000000, 0xfffffe01 all map to set 0
    plan.push_back(mk(ACT_INSERT, 32'h8000_0000, 48'hffff_ffff_ffff));
    plan.push_back(mk(ACT_INSERT, 32'h0000_0200, 48'h1234_5678_9abc));
    plan.push_back(mk(ACT_INSERT, 32'hffff_fe01, 48'h8000_0000_0001));
    plan.push_back(mk(ACT_LOOKUP, 32'h8000_0000, 48'h0));
    plan.push_back(mk(ACT_INSERT, 32'h0000_0200, 48'h0000_0000_0007));
    plan.push_back(mk(ACT_LOOKUP, 32'h0000_0200, 48'h0));
    plan.push_back(mk(ACT_LOOKUP, 32'h0, 48'h0));
    plan.push_back(mk(ACT_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff));
    plan.push_back(mk(ACT_LOOKUP, 32'hffff_ffff, 48'h0));
    plan.push_back(mk(ACT_INV_ADDR, 32'h0000_0200, 48'h0));
    plan.push_back(mk(ACT_INSERT, 32'h0000_0600, 48'h5555_aaaa_5555));
    plan.push_back(mk(ACT_INV_DATA, 32'h0, 48'hffff_ffff_ffff));
    plan.push_back(mk(ACT_INV_DATA, 32'h0, 48'hffff_ffff_ffff));
    plan.push_back(mk(ACT_LOOKUP, 32'h8000_0000, 48'h0));
    plan.push_back(mk(ACT_INV_ALL, 32'h0, 48'h0, 1));
    plan.push_back(mk(ACT_LOOKUP, 32'h0000_0600, 48'h0, 1));
    foreach (plan[i])
      send_item(plan[i].action, plan[i].address, plan[i].entry_data,
                plan[i].fixed, plan[i].reply);

    shifts = '{SET_SHIFT_RESET, 5'd0, 5'd31, 5'd7, SHIFT_W'($urandom), 5'd2};
    foreach (shifts[p]) begin
      drain_and_pause();
      write_shift(shifts[p]);
      phases_run++;
      for (int n = 0; n < 290; n++) begin
        if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
        random_item();
      end
      calm = 1'b0;
    end

    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("%0d items over %0d shift settings, %0d results checked, %0d hits",
             items_sent, phases_run, replies_seen, hits_seen);
    if (mismatches == 0) $display("set_assoc_block_cache_plru_top regression: pass");
    else $display("set_assoc_block_cache_plru_top regression: fail");
    $finish;
  end

endmodule

// File: sim.f
src/sabc_pkg.sv
src/sabc_ram.sv
src/sabc_front.sv
src/sabc_back.sv
src/set_assoc_block_cache_plru_top.sv
bench/tb_set_assoc_block_cache_plru_top.sv
